FILE: sv/bttbp_pkg.sv
// Package for the bit text to byte packer.
// Holds character codes, line phase codes, item types and the bit reversal.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bttbp_pkg;

   localparam int unsigned ByteWidth = 8;

   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_ONE     = 8'h31;
   localparam logic [7:0] CHAR_DEFLATE = 8'h44;
   localparam logic [7:0] CHAR_CANON   = 8'h43;
   localparam logic [7:0] CHAR_PAD     = 8'h50;
   localparam logic [7:0] CHAR_REPORT  = 8'h52;
   localparam logic [7:0] CHAR_NEWLINE = 8'h0A;

   localparam logic [1:0] PH_START = 2'd0;
   localparam logic [1:0] PH_BITS  = 2'd1;
   localparam logic [1:0] PH_SKIP  = 2'd2;

   localparam logic KIND_BYTE   = 1'b0;
   localparam logic KIND_REPORT = 1'b1;

   typedef struct packed {
      logic [7:0] char_code;
      logic       end_of_input;
   } req_item_type;

   typedef struct packed {
      logic        result_kind;
      logic [7:0]  byte_value;
      logic [15:0] report_index;
      logic [31:0] byte_count;
      logic [2:0]  bit_offset;
   } rsp_item_type;

   function automatic logic [ByteWidth-1:0] reverse_byte(input logic [ByteWidth-1:0] v);
      logic [ByteWidth-1:0] r;
      for (int i = 0; i < ByteWidth; i++) begin
         r[i] = v[ByteWidth-1-i];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

FILE: sv/bit_text_to_byte_packer_top.sv
// Bit text to byte packer, top level.
// Reads one character per item, packs '0'/'1' runs LSB-first into bytes and
// issues bytes or report records. Depends on bttbp_pkg.
//
// Usage:
//   req channel (valid/ready): one character or an end-of-input marker per item.
//   rsp channel (valid/ready): at most one result per input item, either a
//   packed byte (kind 0) or a report record (kind 1).
//   Output: a result is registered and appears on rsp in the cycle after its item is accepted.
//   Throughput: one item per cycle while rsp is not stalled; the line state and the result register
//   are both updated in the accepting cycle.
//   Stall: the result register holds its item while rsp_ready is low, and
//   req_ready is then low too; items that make no result still wait, so
//   ordering is kept.
//   Reset: line start, empty accumulator, canonical (bit-reversed) order,
//   byte and report counters cleared, no result pending.
//   End of input flushes a partial byte and returns to line start; mode and
//   counters carry on into the next stream.
`timescale 1ns / 1ps
`default_nettype none

module bit_text_to_byte_packer_top (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_valid,
   output logic                   req_ready,
   input  bttbp_pkg::req_item_type req_item,
   output logic                   rsp_valid,
   input  wire                    rsp_ready,
   output bttbp_pkg::rsp_item_type rsp_item
);
   import bttbp_pkg::*;

   logic [1:0]  phase_ff, phase_in;
   logic [7:0]  acc_ff, acc_in;
   logic [2:0]  fill_ff, fill_in;
   logic        canon_ff, canon_in;
   logic [31:0] bytes_ff, bytes_in;
   logic [15:0] reports_ff, reports_in;
   logic        rsp_valid_ff;
   rsp_item_type rsp_item_ff, rsp_item_in;
   logic        emit;

   logic       accept;
   logic       is_bit;
   logic       is_pad;
   logic [7:0] acc_pushed;
   logic [7:0] c;

   assign c          = req_item.char_code;
   assign is_bit     = (c == CHAR_ZERO) || (c == CHAR_ONE);
   assign is_pad     = (c == CHAR_DEFLATE) || (c == CHAR_CANON) || (c == CHAR_PAD);
   assign acc_pushed = acc_ff | ({7'd0, c[0]} << fill_ff);

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   always_comb begin
      logic       do_push;
      logic       do_flush;
      logic [7:0] out_acc;
      do_push     = 1'b0;
      do_flush    = 1'b0;
      out_acc     = acc_ff;
      phase_in    = phase_ff;
      acc_in      = acc_ff;
      fill_in     = fill_ff;
      canon_in    = canon_ff;
      bytes_in    = bytes_ff;
      reports_in  = reports_ff;
      emit        = 1'b0;
      rsp_item_in = '0;

      if (req_item.end_of_input) begin
         phase_in = PH_START;
         do_flush = 1'b1;
      end else begin
         case (phase_ff)
            PH_START: begin
               if (is_bit) begin
                  do_push  = 1'b1;
                  phase_in = PH_BITS;
               end else if (c == CHAR_NEWLINE) begin
                  phase_in = PH_START;
               end else begin
                  phase_in = PH_SKIP;
                  if (is_pad) begin
                     do_flush = 1'b1;
                     if (c == CHAR_DEFLATE) begin
                        canon_in = 1'b0;
                     end else if (c == CHAR_CANON) begin
                        canon_in = 1'b1;
                     end
                  end else if (c == CHAR_REPORT) begin
                     reports_in               = reports_ff + 16'd1;
                     emit                     = 1'b1;
                     rsp_item_in.result_kind  = KIND_REPORT;
                     rsp_item_in.report_index = reports_ff + 16'd1;
                     rsp_item_in.byte_count   = bytes_ff;
                     rsp_item_in.bit_offset   = fill_ff;
                  end
               end
            end
            PH_BITS: begin
               if (is_bit) begin
                  do_push = 1'b1;
               end else begin
                  phase_in = (c == CHAR_NEWLINE) ? PH_START : PH_SKIP;
               end
            end
            default: begin
               phase_in = (c == CHAR_NEWLINE) ? PH_START : PH_SKIP;
            end
         endcase
      end

      if (do_push) begin
         if (fill_ff == 3'd7) begin
            emit    = 1'b1;
            out_acc = acc_pushed;
         end else begin
            acc_in  = acc_pushed;
            fill_in = fill_ff + 3'd1;
         end
      end
      if (do_flush && (fill_ff != 3'd0)) begin
         emit    = 1'b1;
         out_acc = acc_ff;
      end
      if (emit && (rsp_item_in.result_kind == KIND_BYTE)) begin
         acc_in                 = '0;
         fill_in                = '0;
         bytes_in               = bytes_ff + 32'd1;
         rsp_item_in.byte_value = canon_ff ? reverse_byte(out_acc) : out_acc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_START;
         acc_ff       <= '0;
         fill_ff      <= '0;
         canon_ff     <= 1'b1;
         bytes_ff     <= '0;
         reports_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         phase_ff     <= phase_in;
         acc_ff       <= acc_in;
         fill_ff      <= fill_in;
         canon_ff     <= canon_in;
         bytes_ff     <= bytes_in;
         reports_ff   <= reports_in;
         rsp_valid_ff <= emit;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && emit) begin
         rsp_item_ff <= rsp_item_in;
      end
   end

endmodule

`default_nettype wire
